>>> hdl/udse_pkg.sv
// Shared constants and types for the URL domain suffix extractor.
package udse_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 12;
    localparam int unsigned LABEL_W     = 3;
    localparam int unsigned TAIL_DEPTH  = 6;

    localparam int unsigned MAX_DOMAIN_LENGTH_DEFAULT = 4095;
    localparam int unsigned COUNT_CAP   = 4095;

    localparam logic [BYTE_W-1:0]  SLASH_CHAR  = 8'h2F;
    localparam logic [BYTE_W-1:0]  DOT_CHAR    = 8'h2E;
    localparam logic [LABEL_W-1:0] COUNTRY_LEN = 3'd2;
    localparam logic [LABEL_W-1:0] TYPE_LEN    = 3'd3;
    localparam logic [LABEL_W-1:0] LABEL_MAX   = 3'd7;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [COUNT_W-1:0] domain_length;
        logic               length_overflow;
        logic               country_valid;
        byte_t              country_first;
        byte_t              country_second;
        logic               type_valid;
        byte_t              type_first;
        byte_t              type_second;
        byte_t              type_third;
    } result_word_t;

endpackage

>>> hdl/udse_stream_if.sv
// Valid/ready channels for URL bytes in and domain results out.
interface udse_byte_if;
    logic                        valid;
    logic                        ready;
    logic [udse_pkg::BYTE_W-1:0] url_byte;
    logic                        last_byte;

    modport source (output valid, output url_byte, output last_byte, input ready);
    modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

interface udse_result_if;
    logic                         valid;
    logic                         ready;
    logic [udse_pkg::COUNT_W-1:0] domain_length;
    logic                         length_overflow;
    logic                         country_valid;
    logic [udse_pkg::BYTE_W-1:0]  country_first;
    logic [udse_pkg::BYTE_W-1:0]  country_second;
    logic                         type_valid;
    logic [udse_pkg::BYTE_W-1:0]  type_first;
    logic [udse_pkg::BYTE_W-1:0]  type_second;
    logic [udse_pkg::BYTE_W-1:0]  type_third;

    modport source (
        output valid, output domain_length, output length_overflow,
        output country_valid, output country_first, output country_second,
        output type_valid, output type_first, output type_second, output type_third,
        input ready
    );
    modport sink (
        input valid, input domain_length, input length_overflow,
        input country_valid, input country_first, input country_second,
        input type_valid, input type_first, input type_second, input type_third,
        output ready
    );
endinterface

>>> hdl/url_domain_suffix_extractor_core.sv
// Top level: streaming URL domain length, country and type label extractor.
//
// Usage:
//   in_ch carries one URL byte per word, last_byte marking the final byte.
//   out_ch carries one result word per URL, produced by the word that has
//   last_byte set; other words only update the running state.
//   The result is registered: it is valid in the cycle after its last byte is taken.
//   Throughput: one byte per cycle across URL boundaries, while the receiver
//   keeps taking results; the per-byte update is a 12-bit saturating
//   increment, a 6-byte shift and two 3-bit label counters, all combinational.
//   The result register parts the two sides: input stays ready while the
//   register is empty or being drained this cycle. When the receiver stalls
//   with a result held, input is held off only until that result is taken.
//   Reset (rst_n low, asynchronous) clears the count, flags, label lengths,
//   tail and the result valid; the block is ready in the first cycle after.
//   Each URL ends with the state returned to its reset values.
//   The domain length saturates at the smaller of MAX_DOMAIN_LENGTH and 4095.
module url_domain_suffix_extractor_core #(
    parameter int unsigned MAX_DOMAIN_LENGTH = udse_pkg::MAX_DOMAIN_LENGTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    udse_byte_if.sink     in_ch,
    udse_result_if.source out_ch
);

    localparam int unsigned LimitInt =
        (MAX_DOMAIN_LENGTH > udse_pkg::COUNT_CAP) ? udse_pkg::COUNT_CAP : MAX_DOMAIN_LENGTH;
    localparam logic [udse_pkg::COUNT_W-1:0] CountLimit = udse_pkg::COUNT_W'(LimitInt);

    // Running per-URL state
    logic [udse_pkg::COUNT_W-1:0] count_reg,      count_next;
    logic                         slash_reg,      slash_next;
    logic                         dot_reg,        dot_next;
    logic [udse_pkg::LABEL_W-1:0] final_len_reg,  final_len_next;
    logic [udse_pkg::LABEL_W-1:0] prev_len_reg,   prev_len_next;
    udse_pkg::byte_t              tail_reg  [udse_pkg::TAIL_DEPTH];
    udse_pkg::byte_t              tail_next [udse_pkg::TAIL_DEPTH];

    // Result register
    logic                   out_valid_reg, out_valid_next;
    udse_pkg::result_word_t res_reg,       res_next;

    // State after the current byte, before any end-of-URL clear
    logic [udse_pkg::COUNT_W-1:0] count_upd;
    logic                         slash_upd;
    logic                         dot_upd;
    logic [udse_pkg::LABEL_W-1:0] final_len_upd;
    logic [udse_pkg::LABEL_W-1:0] prev_len_upd;
    udse_pkg::byte_t              tail_upd [udse_pkg::TAIL_DEPTH];

    logic in_accept;
    logic take_byte;
    logic is_dot;
    logic country_hit;

    // Accept while the result register is empty or emptying this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign take_byte = !slash_reg && (in_ch.url_byte != udse_pkg::SLASH_CHAR);
    assign is_dot    = (in_ch.url_byte == udse_pkg::DOT_CHAR);

    // Per-byte update of the domain state
    always_comb
    begin
        count_upd     = count_reg;
        slash_upd     = slash_reg || (in_ch.url_byte == udse_pkg::SLASH_CHAR);
        dot_upd       = dot_reg;
        final_len_upd = final_len_reg;
        prev_len_upd  = prev_len_reg;
        for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
        begin
            tail_upd[i] = tail_reg[i];
        end
        if (take_byte)
        begin
            if (count_reg < CountLimit)
            begin
                count_upd = count_reg + 1'b1;
            end
            // shift the tail, newest byte last
            for (int i = 0; i < udse_pkg::TAIL_DEPTH - 1; i++)
            begin
                tail_upd[i] = tail_reg[i+1];
            end
            tail_upd[udse_pkg::TAIL_DEPTH-1] = in_ch.url_byte;
            if (is_dot)
            begin
                dot_upd       = 1'b1;
                prev_len_upd  = final_len_reg;
                final_len_upd = '0;
            end
            else if (final_len_reg < udse_pkg::LABEL_MAX)
            begin
                final_len_upd = final_len_reg + 1'b1;
            end
        end
    end

    // Result word from the updated state
    assign country_hit = (final_len_upd == udse_pkg::COUNTRY_LEN);

    always_comb
    begin
        res_next                 = '0;
        res_next.domain_length   = count_upd;
        res_next.length_overflow = (count_upd == CountLimit);
        res_next.country_valid   = country_hit;
        if (country_hit)
        begin
            res_next.country_first  = tail_upd[4];
            res_next.country_second = tail_upd[5];
        end
        if (final_len_upd == udse_pkg::TYPE_LEN)
        begin
            // final label is itself the type
            res_next.type_valid  = 1'b1;
            res_next.type_first  = tail_upd[3];
            res_next.type_second = tail_upd[4];
            res_next.type_third  = tail_upd[5];
        end
        else if (country_hit && dot_upd && (prev_len_upd == udse_pkg::TYPE_LEN))
        begin
            // type label sits just before the country code
            res_next.type_valid  = 1'b1;
            res_next.type_first  = tail_upd[0];
            res_next.type_second = tail_upd[1];
            res_next.type_third  = tail_upd[2];
        end
    end

    // Next state: hold when idle, advance on a word, clear at end of URL
    always_comb
    begin
        count_next     = count_reg;
        slash_next     = slash_reg;
        dot_next       = dot_reg;
        final_len_next = final_len_reg;
        prev_len_next  = prev_len_reg;
        for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
        begin
            tail_next[i] = tail_reg[i];
        end
        if (in_accept)
        begin
            if (in_ch.last_byte)
            begin
                count_next     = '0;
                slash_next     = 1'b0;
                dot_next       = 1'b0;
                final_len_next = '0;
                prev_len_next  = '0;
                for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
                begin
                    tail_next[i] = '0;
                end
            end
            else
            begin
                count_next     = count_upd;
                slash_next     = slash_upd;
                dot_next       = dot_upd;
                final_len_next = final_len_upd;
                prev_len_next  = prev_len_upd;
                for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
                begin
                    tail_next[i] = tail_upd[i];
                end
            end
        end
    end

    // Result valid: load on a last byte, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept && in_ch.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            slash_reg     <= 1'b0;
            dot_reg       <= 1'b0;
            final_len_reg <= '0;
            prev_len_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg     <= count_next;
            slash_reg     <= slash_next;
            dot_reg       <= dot_next;
            final_len_reg <= final_len_next;
            prev_len_reg  <= prev_len_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < udse_pkg::TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept && in_ch.last_byte)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.domain_length   = res_reg.domain_length;
    assign out_ch.length_overflow = res_reg.length_overflow;
    assign out_ch.country_valid   = res_reg.country_valid;
    assign out_ch.country_first   = res_reg.country_first;
    assign out_ch.country_second  = res_reg.country_second;
    assign out_ch.type_valid      = res_reg.type_valid;
    assign out_ch.type_first      = res_reg.type_first;
    assign out_ch.type_second     = res_reg.type_second;
    assign out_ch.type_third      = res_reg.type_third;

endmodule

>>> hdl/udse_checker.sv
// Port-level checks for the URL domain suffix extractor, bound to the top level.
module udse_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         last_byte,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [udse_pkg::COUNT_W-1:0] domain_length,
    input logic                         country_valid,
    input logic [udse_pkg::BYTE_W-1:0]  country_first,
    input logic [udse_pkg::BYTE_W-1:0]  country_second,
    input logic                         type_valid,
    input logic [udse_pkg::BYTE_W-1:0]  type_first,
    input logic [udse_pkg::BYTE_W-1:0]  type_second,
    input logic [udse_pkg::BYTE_W-1:0]  type_third
);

    // a last byte always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> out_valid)
        else $error("last byte gave no result");

    // draining the result must leave the input side open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input blocked while result drains");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(domain_length))
        else $error("stalled result changed");

    // invalid suffix fields read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !country_valid |-> country_first == '0 && country_second == '0)
        else $error("country bytes set without country");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !type_valid |->
            type_first == '0 && type_second == '0 && type_third == '0)
        else $error("type bytes set without type");

endmodule

bind url_domain_suffix_extractor_core udse_checker u_udse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .last_byte      (in_ch.last_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .domain_length  (out_ch.domain_length),
    .country_valid  (out_ch.country_valid),
    .country_first  (out_ch.country_first),
    .country_second (out_ch.country_second),
    .type_valid     (out_ch.type_valid),
    .type_first     (out_ch.type_first),
    .type_second    (out_ch.type_second),
    .type_third     (out_ch.type_third)
);

>>> tb/udse_checker.sv
// Checker for the URL domain suffix extractor: predicts each result word and compares it.
`timescale 1ns / 1ps

module udse_scoreboard
    import udse_pkg::*;
#(
    parameter int unsigned MAX_DOMAIN_LENGTH = MAX_DOMAIN_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    udse_byte_if        in_mon,
    udse_result_if      out_mon,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned results_seen,
    output int unsigned country_seen,
    output int unsigned type_seen,
    output int unsigned saturated_seen
);

    localparam logic [COUNT_W-1:0] LEN_LIMIT =
        (MAX_DOMAIN_LENGTH > COUNT_CAP) ? COUNT_CAP[COUNT_W-1:0] : MAX_DOMAIN_LENGTH[COUNT_W-1:0];

    // Running view of the URL in flight.
    logic [COUNT_W-1:0] dom_count;
    logic               past_slash;
    logic               has_dot;
    logic [LABEL_W-1:0] last_label_len;
    logic [LABEL_W-1:0] prior_label_len;
    byte_t              tail [TAIL_DEPTH];

    result_word_t       suffix_q [$];

    function automatic void clear_url();
        dom_count       = '0;
        past_slash      = 1'b0;
        has_dot         = 1'b0;
        last_label_len  = '0;
        prior_label_len = '0;
        foreach (tail[i])
            tail[i] = '0;
    endfunction

    // Fold one byte into the domain view; on the last byte queue the expected word.
    function automatic void absorb_byte(byte_t b, logic is_last);
        result_word_t r;
        if (!past_slash)
        begin
            if (b == SLASH_CHAR)
                past_slash = 1'b1;
            else
            begin
                if (dom_count < LEN_LIMIT)
                    dom_count++;
                for (int i = 0; i < TAIL_DEPTH - 1; i++)
                    tail[i] = tail[i+1];
                tail[TAIL_DEPTH-1] = b;
                if (b == DOT_CHAR)
                begin
                    has_dot         = 1'b1;
                    prior_label_len = last_label_len;
                    last_label_len  = '0;
                end
                else if (last_label_len < LABEL_MAX)
                    last_label_len++;
            end
        end
        if (!is_last)
            return;
        r                 = '0;
        r.domain_length   = dom_count;
        r.length_overflow = (dom_count == LEN_LIMIT);
        r.country_valid   = (last_label_len == COUNTRY_LEN);
        if (r.country_valid)
        begin
            r.country_first  = tail[TAIL_DEPTH-2];
            r.country_second = tail[TAIL_DEPTH-1];
        end
        if (last_label_len == TYPE_LEN)
        begin
            r.type_valid  = 1'b1;
            r.type_first  = tail[TAIL_DEPTH-3];
            r.type_second = tail[TAIL_DEPTH-2];
            r.type_third  = tail[TAIL_DEPTH-1];
        end
        else if (r.country_valid && has_dot && prior_label_len == TYPE_LEN)
        begin
            r.type_valid  = 1'b1;
            r.type_first  = tail[TAIL_DEPTH-6];
            r.type_second = tail[TAIL_DEPTH-5];
            r.type_third  = tail[TAIL_DEPTH-4];
        end
        suffix_q.push_back(r);
        clear_url();
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            clear_url();
            suffix_q.delete();
            fail_count     = 0;
            pending        = 0;
            results_seen   = 0;
            country_seen   = 0;
            type_seen      = 0;
            saturated_seen = 0;
        end
        else
        begin
            // Compare the outgoing word first: it belongs to an earlier URL.
            if (out_mon.valid && out_mon.ready)
            begin
                if (suffix_q.size() == 0)
                begin
                    $error("result word with no URL outstanding");
                    fail_count++;
                end
                else
                begin
                    want = suffix_q.pop_front();
                    check_field("domain_length", want.domain_length, out_mon.domain_length);
                    check_field("length_overflow", want.length_overflow,
                                out_mon.length_overflow);
                    check_field("country_valid", want.country_valid, out_mon.country_valid);
                    check_field("country_first", want.country_first, out_mon.country_first);
                    check_field("country_second", want.country_second,
                                out_mon.country_second);
                    check_field("type_valid", want.type_valid, out_mon.type_valid);
                    check_field("type_first", want.type_first, out_mon.type_first);
                    check_field("type_second", want.type_second, out_mon.type_second);
                    check_field("type_third", want.type_third, out_mon.type_third);
                    results_seen++;
                    country_seen   += want.country_valid;
                    type_seen      += want.type_valid;
                    saturated_seen += want.length_overflow;
                end
            end
            if (in_mon.valid && in_mon.ready)
                absorb_byte(in_mon.url_byte, in_mon.last_byte);
            pending = suffix_q.size();
        end
    end

endmodule

>>> tb/tb_url_domain_suffix_extractor_core.sv
// Testbench top for the URL domain suffix extractor: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_url_domain_suffix_extractor_core;
    import udse_pkg::*;

    localparam int unsigned ITEM_TARGET    = 750;   // random bytes, roughly
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned GAP_MAX        = 10;    // longest idle per word, either side
    localparam int unsigned HOLD_AT_RESULT = 30;    // result count at which the sink backs off
    localparam int unsigned HOLD_CYCLES    = 200;   // length of that back-off
    localparam int unsigned SETTLE_CYCLES  = 4;     // results are registered, valid in the cycle after the last byte
    localparam int unsigned RUN_LIMIT_NS   = 3_000_000;

    logic clk = 1'b0;
    logic rst_n;

    udse_byte_if   byte_ch ();
    udse_result_if result_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned country_seen;
    int unsigned type_seen;
    int unsigned saturated_seen;

    // Idle ceilings per side; zero gives a stretch at full rate.
    int unsigned send_gap_max;
    int unsigned take_gap_max;
    int unsigned bytes_sent;
    int unsigned results_taken;

    always #5 clk = ~clk;

    url_domain_suffix_extractor_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (result_ch)
    );

    udse_scoreboard u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (byte_ch),
        .out_mon        (result_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .country_seen   (country_seen),
        .type_seen      (type_seen),
        .saturated_seen (saturated_seen)
    );

    // Offer one word. Entered and left at a falling edge; valid is only
    // lowered when an idle gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input byte_t b, input logic is_last);
        int unsigned gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.url_byte  <= b;
        byte_ch.last_byte <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_url(input byte_t url[$]);
        foreach (url[i])
            send_word(url[i], i == url.size() - 1);
    endtask

    task automatic send_text(input string s);
        byte_t url[$];
        for (int i = 0; i < s.len(); i++)
            url.push_back(s[i]);
        send_url(url);
    endtask

    // Label characters: mostly lower-case letters, sometimes any byte that
    // is neither a separator nor a slash.
    function automatic byte_t label_char();
        byte_t c;
        if ($urandom_range(3, 0) != 0)
            return byte_t'("a") + byte_t'($urandom_range(25, 0));
        do
            c = byte_t'($urandom_range(255, 0));
        while (c == DOT_CHAR || c == SLASH_CHAR);
        return c;
    endfunction

    // Build one random URL: mostly dotted host names with random label sizes
    // (weighted towards two and three bytes) and an optional path; the rest
    // is raw noise rich in separators and slashes.
    function automatic void make_url(ref byte_t url[$]);
        int unsigned labels;
        int unsigned len;
        url.delete();
        if ($urandom_range(9, 0) < 7)
        begin
            labels = $urandom_range(4, 1);
            for (int l = 0; l < labels; l++)
            begin
                if (l > 0)
                    url.push_back(DOT_CHAR);
                case ($urandom_range(5, 0))
                    0, 1:    len = 2;
                    2, 3:    len = 3;
                    4:       len = $urandom_range(1, 0);
                    default: len = $urandom_range(9, 0);
                endcase
                repeat (len)
                    url.push_back(label_char());
            end
            case ($urandom_range(3, 0))
                0:
                begin
                    url.push_back(SLASH_CHAR);
                    repeat ($urandom_range(6, 0))
                        url.push_back(byte_t'($urandom_range(255, 0)));
                end
                1:       url.push_back(SLASH_CHAR);
                default: ;
            endcase
        end
        else
        begin
            repeat ($urandom_range(12, 1))
            begin
                case ($urandom_range(3, 0))
                    0:       url.push_back(DOT_CHAR);
                    1:       url.push_back(SLASH_CHAR);
                    default: url.push_back(byte_t'($urandom_range(255, 0)));
                endcase
            end
        end
        if (url.size() == 0)
            url.push_back(label_char());
    endfunction

    // Sink side: draw an idle gap before each result word, except once, when
    // the sink backs off for a long stretch so that the result register
    // fills and the block has to hold off its input.
    initial
    begin
        int unsigned gap;
        result_ch.ready = 1'b0;
        results_taken   = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_taken == HOLD_AT_RESULT)
                gap = HOLD_CYCLES;
            else
                gap = $urandom_range(take_gap_max, 0);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            results_taken++;
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        byte_t url[$];
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.url_byte  = '0;
        byte_ch.last_byte = 1'b0;
        send_gap_max      = GAP_MAX;
        take_gap_max      = GAP_MAX;
        bytes_sent        = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: dotless two-byte country, three-byte type label, type
        // before a country, empty domain ended by a slash, domain ended by a
        // trailing slash, lone separator, extreme byte values, and bytes
        // after a slash that must be ignored.
        send_text("ab");
        send_text("x.com");
        send_text("gov.cn");
        send_text("/");
        send_text("ab/");
        send_text(".");
        url = {8'h00, 8'hFF};
        send_url(url);
        send_text("q/x.c");

        // Random URLs; every so often a stretch with no idling on either side.
        while (bytes_sent < ITEM_TARGET)
        begin
            if ($urandom_range(7, 0) == 0)
            begin
                send_gap_max = 0;
                take_gap_max = 0;
            end
            else
            begin
                send_gap_max = GAP_MAX;
                take_gap_max = GAP_MAX;
            end
            make_url(url);
            send_url(url);
        end

        byte_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d URL bytes; checked %0d result words.", bytes_sent, results_seen);
        $display("Of those, %0d had a country code, %0d a type label, %0d a saturated length.",
                 country_seen, type_seen, saturated_seen);
        if (fail_count == 0)
            $display("url_domain_suffix_extractor_core: match");
        else
            $display("url_domain_suffix_extractor_core: mismatch");
        $finish;
    end

    // Hard stop if the stream stalls.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d result words still outstanding.", pending);
        $display("url_domain_suffix_extractor_core: mismatch");
        $finish;
    end

endmodule

>>> files.f
hdl/udse_pkg.sv
hdl/udse_stream_if.sv
hdl/url_domain_suffix_extractor_core.sv
hdl/udse_checker.sv
tb/udse_checker.sv
tb/tb_url_domain_suffix_extractor_core.sv
